>>> rtl/spd_pkg.sv
package spd_pkg;

  localparam int IMAGE_WIDTH  = 320;
  localparam int IMAGE_HEIGHT = 240;
  localparam int SERVO_CENTER = 1500;

  localparam int HALF_WIDTH = IMAGE_WIDTH / 2;
  localparam int ERR_STEP   = IMAGE_WIDTH / 10;
  localparam int ROW_LIMIT  = IMAGE_HEIGHT / 2;

  localparam int CLAMP_SLOW      = 300;
  localparam int CLAMP_NORMAL    = 450;
  localparam int SIGMA_LIMIT     = 100;
  localparam int SHIFT_MAX       = 10;
  localparam int SHIFT_MID       = 5;
  localparam int MIN_EDGE_POINTS = 10;

  localparam int CFG_NUM = 6;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 16;

  localparam logic [CFG_AW-1:0] REG_P_BASE_NORMAL  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_P_SLOPE_NORMAL = 3'd1;
  localparam logic [CFG_AW-1:0] REG_D_GAIN_NORMAL  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_P_BASE_SLOW    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_P_SLOPE_SLOW   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_D_GAIN_SLOW    = 3'd5;

  localparam logic [1:0] SPEED_LOW  = 2'd0;
  localparam logic [1:0] SPEED_HIGH = 2'd1;
  localparam logic [1:0] SPEED_SLOW = 2'd2;

  localparam int ERR_W  = 11;
  localparam int DERR_W = 8;
  localparam int MA_W   = 28;
  localparam int ACC_W  = 40;
  localparam int Q_FRAC = 12;

  typedef struct packed {
    logic                     en;
    logic signed [MA_W-1:0]   a;
    logic signed [ERR_W-1:0]  b;
    logic signed [ACC_W-1:0]  c;
  } mac_op_t;

  typedef struct packed {
    logic               upd;
    logic               accel;
    logic               slow;
    logic [9:0]         points;
    logic [9:0]         row;
    logic signed [15:0] sigma;
  } shift_req_t;

endpackage

>>> rtl/spd_mac.sv
module spd_mac (
  input  logic                              clk,
  input  spd_pkg::mac_op_t                  op,
  output logic signed [spd_pkg::ACC_W-1:0]  acc
);

  logic signed [spd_pkg::ACC_W-1:0] acc_r;
  logic signed [spd_pkg::ACC_W-1:0] acc_nxt;
  logic signed [spd_pkg::MA_W+spd_pkg::ERR_W-1:0] prod;

  always_comb begin
    prod    = op.a * op.b;
    acc_nxt = op.c + spd_pkg::ACC_W'(prod);
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> rtl/spd_shift.sv
module spd_shift (
  input  logic                clk,
  input  logic                rst_n,
  input  spd_pkg::shift_req_t req,
  output logic [1:0]          speed,
  output logic [1:0]          speed_next
);

  logic [3:0] count_r, count_nxt;
  logic [1:0] speed_r, speed_nxt;
  logic       calm;

  always_comb begin
    calm      = (req.sigma < 16'(spd_pkg::SIGMA_LIMIT)) &&
                (req.sigma > -16'(spd_pkg::SIGMA_LIMIT));
    count_nxt = count_r;
    speed_nxt = speed_r;
    if (req.upd) begin
      if (req.slow) begin
        count_nxt = '0;
        speed_nxt = spd_pkg::SPEED_SLOW;
      end else if (!req.accel) begin
        count_nxt = '0;
        speed_nxt = spd_pkg::SPEED_LOW;
      end else if ((req.points < 10'(spd_pkg::MIN_EDGE_POINTS)) ||
                   (req.row > 10'(spd_pkg::ROW_LIMIT))) begin
        count_nxt = '0;
        speed_nxt = spd_pkg::SPEED_LOW;
      end else begin
        if (calm) begin
          if (count_r < 4'(spd_pkg::SHIFT_MAX)) begin
            count_nxt = count_r + 4'd1;
          end
        end else begin
          if (count_r != 4'd0) begin
            count_nxt = count_r - 4'd1;
          end
        end
        speed_nxt = (count_nxt > 4'(spd_pkg::SHIFT_MID)) ? spd_pkg::SPEED_HIGH
                                                          : spd_pkg::SPEED_LOW;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      speed_r <= spd_pkg::SPEED_LOW;
    end else begin
      count_r <= count_nxt;
      speed_r <= speed_nxt;
    end
  end

  assign speed      = speed_r;
  assign speed_next = speed_nxt;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 4'(spd_pkg::SHIFT_MAX))
    else $error("shift count out of range");

  a_high_needs_count: assert property (@(posedge clk) disable iff (!rst_n)
    (speed_r == spd_pkg::SPEED_HIGH) |-> (count_r > 4'(spd_pkg::SHIFT_MID)))
    else $error("high speed without enough count");

  a_slow_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (req.upd && req.slow) |=> (speed_r == spd_pkg::SPEED_SLOW) && (count_r == 4'd0))
    else $error("slow-down request not taken");

endmodule

>>> rtl/steering_pd_with_speed_shift.sv
// An accepted item steps through LIMIT, GAIN, PROP, DERIV, MAG and FIN, where it
// waits for a free output register; no new item is taken before then. The shared
// multiply-accumulate unit is used three times per item under the sequencer.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) clears the gain registers, the prior error,
// the shift counter and the stored speed choice (low speed).
module steering_pd_with_speed_shift (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [spd_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [spd_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // center_column[9:0], accel_enable[10], slow_down[11], edge_points[21:12],
  // last_edge_row[31:22], sigma_center[47:32]
  input  logic [47:0]                 in_tdata,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // servo_pwm[15:0], speed_code[17:16], steer_error[27:18], zero[31:28]
  output logic [31:0]                 out_tdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LIMIT = 3'd1;
  localparam logic [2:0] S_GAIN  = 3'd2;
  localparam logic [2:0] S_PROP  = 3'd3;
  localparam logic [2:0] S_DERIV = 3'd4;
  localparam logic [2:0] S_MAG   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  localparam int Q_SH = spd_pkg::Q_FRAC;

  logic [2:0] state_r, state_nxt;
  logic [spd_pkg::CFG_DW-1:0] cfg_r [spd_pkg::CFG_NUM];

  logic [9:0]         cc_r;
  logic               accel_r, slow_r;
  logic [9:0]         points_r, row_r;
  logic signed [15:0] sigma_r;

  logic signed [spd_pkg::ERR_W-1:0]  prior_r, err_r;
  logic signed [spd_pkg::DERR_W-1:0] derr_r;
  logic [9:0]                        abs_r;
  logic                              slow_mode_r;
  logic [spd_pkg::ACC_W-Q_SH-1:0]    mag_r;
  logic                              neg_r;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic signed [spd_pkg::ERR_W-1:0]  raw, err_lim, dfull;
  logic signed [spd_pkg::ERR_W:0]    diff;
  logic signed [spd_pkg::ACC_W-1:0]  acc, acc_abs;
  logic [8:0]                        lim, mag_c;
  logic signed [9:0]                 corr;
  logic [15:0]                       pwm;
  logic signed [9:0]                 err_sat;
  logic [15:0]                       base, slope, dgain;
  logic                              load_out, accept;
  logic [1:0]                        speed, speed_new;
  spd_pkg::mac_op_t                  mop;
  spd_pkg::shift_req_t               sreq;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign load_out  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < spd_pkg::CFG_NUM; i++) begin
        cfg_r[i] <= '0;
      end
    end else if (cfg_we && (cfg_index < spd_pkg::CFG_AW'(spd_pkg::CFG_NUM))) begin
      cfg_r[cfg_index] <= cfg_wdata;
    end
  end

  always_comb begin
    base  = slow_mode_r ? cfg_r[spd_pkg::REG_P_BASE_SLOW]  : cfg_r[spd_pkg::REG_P_BASE_NORMAL];
    slope = slow_mode_r ? cfg_r[spd_pkg::REG_P_SLOPE_SLOW] : cfg_r[spd_pkg::REG_P_SLOPE_NORMAL];
    dgain = slow_mode_r ? cfg_r[spd_pkg::REG_D_GAIN_SLOW]  : cfg_r[spd_pkg::REG_D_GAIN_NORMAL];
  end

  always_comb begin
    raw  = $signed({1'b0, cc_r}) - spd_pkg::ERR_W'(spd_pkg::HALF_WIDTH);
    diff = {raw[spd_pkg::ERR_W-1], raw} - {prior_r[spd_pkg::ERR_W-1], prior_r};
    if ((diff > $signed((spd_pkg::ERR_W+1)'(spd_pkg::ERR_STEP))) ||
        (diff < -$signed((spd_pkg::ERR_W+1)'(spd_pkg::ERR_STEP)))) begin
      err_lim = (raw > prior_r) ? prior_r + spd_pkg::ERR_W'(spd_pkg::ERR_STEP)
                                : prior_r - spd_pkg::ERR_W'(spd_pkg::ERR_STEP);
    end else begin
      err_lim = raw;
    end
    dfull = err_lim - prior_r;
  end

  always_comb begin
    mop.en = 1'b0;
    mop.a  = '0;
    mop.b  = '0;
    mop.c  = '0;
    unique case (state_r)
      S_GAIN: begin
        mop.en = 1'b1;
        mop.a  = $signed({{(spd_pkg::MA_W-16){1'b0}}, slope});
        mop.b  = $signed({1'b0, abs_r});
        mop.c  = $signed({{(spd_pkg::ACC_W-16){1'b0}}, base});
      end
      S_PROP: begin
        mop.en = 1'b1;
        mop.a  = acc[spd_pkg::MA_W-1:0];
        mop.b  = err_r;
      end
      S_DERIV: begin
        mop.en = 1'b1;
        mop.a  = $signed({{(spd_pkg::MA_W-16){1'b0}}, dgain});
        mop.b  = {{(spd_pkg::ERR_W-spd_pkg::DERR_W){derr_r[spd_pkg::DERR_W-1]}}, derr_r};
        mop.c  = acc;
      end
      default: begin
        mop.en = 1'b0;
      end
    endcase
  end

  spd_mac u_mac (
    .clk (clk),
    .op  (mop),
    .acc (acc)
  );

  always_comb begin
    acc_abs = acc[spd_pkg::ACC_W-1] ? -acc : acc;
    lim     = slow_mode_r ? 9'(spd_pkg::CLAMP_SLOW) : 9'(spd_pkg::CLAMP_NORMAL);
    mag_c   = (mag_r > (spd_pkg::ACC_W-Q_SH)'(lim)) ? lim : mag_r[8:0];
    corr    = neg_r ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    pwm     = 16'(spd_pkg::SERVO_CENTER) - {{6{corr[9]}}, corr};
    if (err_r > 11'sd511) begin
      err_sat = 10'sd511;
    end else if (err_r < -11'sd512) begin
      err_sat = -10'sd512;
    end else begin
      err_sat = err_r[9:0];
    end
  end

  always_comb begin
    sreq.upd    = load_out;
    sreq.accel  = accel_r;
    sreq.slow   = slow_r;
    sreq.points = points_r;
    sreq.row    = row_r;
    sreq.sigma  = sigma_r;
  end

  spd_shift u_shift (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (sreq),
    .speed      (speed),
    .speed_next (speed_new)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept) state_nxt = S_LIMIT;
      S_LIMIT: state_nxt = S_GAIN;
      S_GAIN:  state_nxt = S_PROP;
      S_PROP:  state_nxt = S_DERIV;
      S_DERIV: state_nxt = S_MAG;
      S_MAG:   state_nxt = S_FIN;
      S_FIN:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      prior_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_LIMIT) begin
        prior_r <= err_lim;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cc_r     <= in_tdata[9:0];
      accel_r  <= in_tdata[10];
      slow_r   <= in_tdata[11];
      points_r <= in_tdata[21:12];
      row_r    <= in_tdata[31:22];
      sigma_r  <= $signed(in_tdata[47:32]);
    end
    if (state_r == S_LIMIT) begin
      err_r       <= err_lim;
      derr_r      <= dfull[spd_pkg::DERR_W-1:0];
      abs_r       <= err_lim[spd_pkg::ERR_W-1] ? 10'(-err_lim) : err_lim[9:0];
      slow_mode_r <= (speed == spd_pkg::SPEED_SLOW);
    end
    if (state_r == S_MAG) begin
      mag_r <= acc_abs[spd_pkg::ACC_W-1:Q_SH];
      neg_r <= acc[spd_pkg::ACC_W-1];
    end
    if (load_out) begin
      out_data_r <= {4'd0, err_sat, speed_new, pwm};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  // Fields from the most significant bit down, so that the packed value matches the bus.
  typedef struct packed {
    logic signed [15:0] sigma_center;
    logic [9:0]         last_edge_row;
    logic [9:0]         edge_points;
    logic               slow_down;
    logic               accel_enable;
    logic [9:0]         center_column;
  } frame_t;

  typedef struct packed {
    logic signed [9:0] steer_error;
    logic [1:0]        speed_code;
    logic [15:0]       servo_pwm;
  } steer_result_t;

  typedef logic [spd_pkg::CFG_DW-1:0] gain_set_t [spd_pkg::CFG_NUM];

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [spd_pkg::CFG_AW-1:0]   cfg_index;
  logic [spd_pkg::CFG_DW-1:0]   cfg_wdata;
  logic                         in_tvalid;
  logic                         in_tready;
  // center_column[9:0], accel_enable[10], slow_down[11], edge_points[21:12],
  // last_edge_row[31:22], sigma_center[47:32]
  logic [47:0]                  in_tdata;
  logic                         out_tvalid;
  logic                         out_tready;
  // servo_pwm[15:0], speed_code[17:16], steer_error[27:18], zero[31:28]
  logic [31:0]                  out_tdata;

  steering_pd_with_speed_shift uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  logic [spd_pkg::CFG_DW-1:0] gain_regs [spd_pkg::CFG_NUM] = '{default: '0};
  int                prior_err = 0;
  int                shift_cnt = 0;
  logic [1:0]        speed_sel = spd_pkg::SPEED_LOW;
  steer_result_t     pending_results [$];
  int                errors = 0;
  bit                no_idle = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic steer_result_t steer_step(input frame_t f);
    int            err;
    int            delta;
    int            used;
    bit            slow_mode;
    longint        base;
    longint        slope;
    longint        dgain;
    longint        lim;
    longint        gain;
    longint        total;
    longint        mag;
    longint        corr;
    steer_result_t r;
    err = int'(f.center_column) - spd_pkg::HALF_WIDTH;
    delta = err - prior_err;
    if (delta > spd_pkg::ERR_STEP || delta < -spd_pkg::ERR_STEP) begin
      err = (err > prior_err) ? prior_err + spd_pkg::ERR_STEP : prior_err - spd_pkg::ERR_STEP;
    end
    slow_mode = (speed_sel == spd_pkg::SPEED_SLOW);
    base  = gain_regs[slow_mode ? spd_pkg::REG_P_BASE_SLOW : spd_pkg::REG_P_BASE_NORMAL];
    slope = gain_regs[slow_mode ? spd_pkg::REG_P_SLOPE_SLOW : spd_pkg::REG_P_SLOPE_NORMAL];
    dgain = gain_regs[slow_mode ? spd_pkg::REG_D_GAIN_SLOW : spd_pkg::REG_D_GAIN_NORMAL];
    lim   = slow_mode ? spd_pkg::CLAMP_SLOW : spd_pkg::CLAMP_NORMAL;
    gain  = base + slope * longint'(err < 0 ? -err : err);
    total = longint'(err) * gain + longint'(err - prior_err) * dgain;
    mag   = (total < 0 ? -total : total) >>> spd_pkg::Q_FRAC;
    corr  = (total < 0) ? -mag : mag;
    if (corr > lim) corr = lim;
    if (corr < -lim) corr = -lim;
    r.servo_pwm = 16'(longint'(spd_pkg::SERVO_CENTER) - corr);
    prior_err = err;

    if (f.slow_down) begin
      shift_cnt = 0;
      speed_sel = spd_pkg::SPEED_SLOW;
    end else if (!f.accel_enable || f.edge_points < spd_pkg::MIN_EDGE_POINTS ||
                 f.last_edge_row > spd_pkg::ROW_LIMIT) begin
      shift_cnt = 0;
      speed_sel = spd_pkg::SPEED_LOW;
    end else begin
      if (f.sigma_center < spd_pkg::SIGMA_LIMIT &&
          f.sigma_center > -spd_pkg::SIGMA_LIMIT) begin
        if (shift_cnt < spd_pkg::SHIFT_MAX) shift_cnt++;
      end else begin
        if (shift_cnt > 0) shift_cnt--;
      end
      speed_sel = (shift_cnt > spd_pkg::SHIFT_MID) ? spd_pkg::SPEED_HIGH : spd_pkg::SPEED_LOW;
    end
    r.speed_code = speed_sel;

    used = err;
    if (used > 511) used = 511;
    if (used < -512) used = -512;
    r.steer_error = 10'(used);
    return r;
  endfunction

  function automatic frame_t mk_frame(input int center, input bit accel, input bit slow,
                                      input int points, input int row, input int sigma);
    frame_t f;
    f.center_column = 10'(center);
    f.accel_enable  = accel;
    f.slow_down     = slow;
    f.edge_points   = 10'(points);
    f.last_edge_row = 10'(row);
    f.sigma_center  = 16'(sigma);
    return f;
  endfunction

  function automatic logic [spd_pkg::CFG_DW-1:0] pick_gain(input int max_val);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return spd_pkg::CFG_DW'($urandom_range(0, max_val));
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  // The item stays valid on return; settle() takes it down, and the next send replaces it.
  task automatic send_frame(input frame_t f);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= f;
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), steer_step(f));
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_put(input int idx, input logic [spd_pkg::CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= spd_pkg::CFG_AW'(idx);
    cfg_wdata <= val;
    @(posedge clk);
    if (idx < spd_pkg::CFG_NUM) gain_regs[idx] = val;
  endtask

  task automatic set_gains(input gain_set_t g);
    settle();
    for (int i = 0; i < spd_pkg::CFG_NUM; i++) cfg_put(i, g[i]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    steer_result_t got;
    steer_result_t want;
    int            stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      got = steer_result_t'(out_tdata[27:0]);
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, servo_pwm", got.servo_pwm, -1);
      end else begin
        want = pending_results.pop_front();
        if (got.servo_pwm !== want.servo_pwm)
          report_mismatch("servo_pwm", got.servo_pwm, want.servo_pwm);
        if (got.speed_code !== want.speed_code)
          report_mismatch("speed_code", got.speed_code, want.speed_code);
        if (got.steer_error !== want.steer_error)
          report_mismatch("steer_error", got.steer_error, want.steer_error);
      end
    end
  end

  task automatic test_zero_gains();
    send_frame(mk_frame(1023, 1'b1, 1'b0, 1023, 0, 0));
    send_frame(mk_frame(0, 1'b0, 1'b0, 0, 1023, -1));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, spd_pkg::MIN_EDGE_POINTS,
                        spd_pkg::ROW_LIMIT, 1));
  endtask

  task automatic test_index_guard();
    settle();
    for (int i = spd_pkg::CFG_NUM; i < (1 << spd_pkg::CFG_AW); i++) cfg_put(i, '1);
    cfg_we <= 1'b0;
    send_frame(mk_frame(1023, 1'b1, 1'b0, 500, 10, 5));
  endtask

  task automatic test_clamp();
    gain_set_t g;
    g = '{default: '1};
    set_gains(g);
    send_frame(mk_frame(1023, 1'b0, 1'b0, 0, 0, 0));
    send_frame(mk_frame(1023, 1'b0, 1'b0, 0, 0, 0));
    send_frame(mk_frame(0, 1'b0, 1'b0, 0, 0, 0));
    send_frame(mk_frame(0, 1'b0, 1'b0, 0, 0, 0));
  endtask

  task automatic test_speed_logic();
    for (int i = 0; i < 3; i++)
      send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, spd_pkg::MIN_EDGE_POINTS,
                          spd_pkg::ROW_LIMIT, spd_pkg::SIGMA_LIMIT - 1));
    for (int i = 0; i < 3; i++)
      send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, 1023, 0, 1 - spd_pkg::SIGMA_LIMIT));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, 1023, 0, spd_pkg::SIGMA_LIMIT));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, 1023, 0, -32768));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, 1023, 0, 0));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, spd_pkg::MIN_EDGE_POINTS - 1, 0, 0));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b0, 1023, spd_pkg::ROW_LIMIT + 1, 0));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b0, 1'b0, 1023, 0, 0));
    // Slow-down takes effect on the steering of the following frames.
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b1, 1'b1, 1023, 0, 32767));
    send_frame(mk_frame(1023, 1'b1, 1'b1, 1023, 0, 0));
    send_frame(mk_frame(0, 1'b0, 1'b1, 0, 1023, 0));
    send_frame(mk_frame(spd_pkg::HALF_WIDTH, 1'b0, 1'b0, 0, 0, 0));
  endtask

  task automatic test_random();
    gain_set_t g;
    frame_t    f;
    int        hold_left;
    int        hold_val;
    int        kind;
    hold_left = 0;
    hold_val  = 0;
    for (int seg = 0; seg < 10; seg++) begin
      g[spd_pkg::REG_P_BASE_NORMAL]  = pick_gain(16384);
      g[spd_pkg::REG_P_SLOPE_NORMAL] = pick_gain(256);
      g[spd_pkg::REG_D_GAIN_NORMAL]  = pick_gain(16384);
      g[spd_pkg::REG_P_BASE_SLOW]    = pick_gain(16384);
      g[spd_pkg::REG_P_SLOPE_SLOW]   = pick_gain(256);
      g[spd_pkg::REG_D_GAIN_SLOW]    = pick_gain(16384);
      set_gains(g);
      no_idle = (seg % 4 == 3);
      for (int n = 0; n < 108; n++) begin
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
          f = frame_t'(48'({$urandom, $urandom}));
        end else begin
          f.accel_enable  = ($urandom_range(0, 29) != 0);
          f.slow_down     = ($urandom_range(0, 39) == 0);
          f.edge_points   = ($urandom_range(0, 7) == 0) ?
                            10'($urandom_range(spd_pkg::MIN_EDGE_POINTS - 1,
                                               spd_pkg::MIN_EDGE_POINTS)) :
                            10'($urandom_range(spd_pkg::MIN_EDGE_POINTS, 1023));
          f.last_edge_row = ($urandom_range(0, 7) == 0) ?
                            10'($urandom_range(spd_pkg::ROW_LIMIT, spd_pkg::ROW_LIMIT + 1)) :
                            10'($urandom_range(0, spd_pkg::ROW_LIMIT));
          f.sigma_center  = ($urandom_range(0, 4) == 0) ? 16'($urandom) :
                            16'(int'($urandom_range(0, 2 * spd_pkg::SIGMA_LIMIT - 2)) -
                                spd_pkg::SIGMA_LIMIT + 1);
          f.center_column = ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                            10'(spd_pkg::HALF_WIDTH - 40 + $urandom_range(0, 80));
        end
        if (hold_left == 0 && $urandom_range(0, 49) == 0) begin
          hold_left = $urandom_range(15, 35);
          hold_val  = $urandom_range(0, 1) ? 1023 : 0;
        end
        if (hold_left > 0) begin
          f.center_column = 10'(hold_val);
          hold_left--;
        end
        send_frame(f);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_gains();
    test_index_guard();
    test_clamp();
    test_speed_logic();
    test_random();
    settle();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
